// ===== rtl/core/pcb_pkg.sv =====
// Shared types, constants and bf16/fp32 arithmetic for the pointwise convolution block.
package pcb_pkg;

    localparam int IN_CH     = 16;
    localparam int OUT_CH    = 32;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 16;
    localparam int W_ROWS    = 8;   // one row per input channel pair
    localparam int W_LANES   = 16;
    localparam int B_ROWS    = 16;  // one row per bias phase
    localparam int B_LANES   = 8;
    localparam int SIZE_W    = 14;
    localparam int CNT_W     = 13;
    localparam int STEP_W    = 5;
    localparam int MAC_STEPS = 16;  // two products per input pair
    localparam int MAX_SIZE  = 8192;

    localparam logic [4:0] STEP_BIAS  = 5'd18;
    localparam logic [4:0] STEP_ROUND = 5'd19;

    localparam logic [31:0] FP_QNAN   = 32'h7FC0_0000;
    localparam logic [15:0] BF_QNAN   = 16'h7FC0;

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_WLOAD = 2'd1,
        ACT_BLOAD = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] pair;
        logic       k;
        logic       add_en;
        logic       add_first;
        logic       add_bias;
    } t_lane_ctl;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    // bf16 x bf16 into fp32; the 8x8 mantissa product is exact, so only range matters
    function automatic logic [31:0] bf_mul(input logic [15:0] a, input logic [15:0] b);
        logic               s;
        logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
        logic [15:0]        m;
        logic signed [10:0] e;
        logic [22:0]        f;
        logic [31:0]        res;
        s      = a[15] ^ b[15];
        a_zero = (a[14:7] == 8'h00);
        b_zero = (b[14:7] == 8'h00);
        a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'h0);
        b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'h0);
        a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'h0);
        b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'h0);
        m      = {1'b1, a[6:0]} * {1'b1, b[6:0]};
        e      = $signed({3'b0, a[14:7]}) + $signed({3'b0, b[14:7]}) - 11'sd127
                 + $signed({10'b0, m[15]});
        f      = m[15] ? {m[14:0], 8'b0} : {m[13:0], 9'b0};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            res = FP_QNAN;
        end else if (a_inf || b_inf) begin
            res = {s, 8'hFF, 23'b0};
        end else if (a_zero || b_zero) begin
            res = {s, 31'b0};
        end else if (e >= 11'sd255) begin
            res = {s, 8'hFF, 23'b0};
        end else if (e <= 11'sd0) begin
            res = {s, 31'b0};
        end else begin
            res = {s, e[7:0], f};
        end
        return res;
    endfunction

    // fp32 add, nearest-even; subnormal operands kept, subnormal results flushed
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf, sub, ru;
        logic [31:0] x, y, res;
        logic [7:0]  ex, ey, d;
        logic [23:0] mx, my;
        logic [49:0] t;
        logic [26:0] al, bg, m;
        logic [27:0] s;
        logic [4:0]  lz, sh;
        logic [8:0]  e;
        logic [24:0] r;
        logic [22:0] frac;
        logic        denorm;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
        res   = FP_QNAN;
        if (a_nan || b_nan) begin
            res = FP_QNAN;
        end else if (a_inf && b_inf) begin
            res = (a[31] != b[31]) ? FP_QNAN : a;
        end else if (a_inf) begin
            res = a;
        end else if (b_inf) begin
            res = b;
        end else begin
            if (a[30:0] >= b[30:0]) begin
                x = a;
                y = b;
            end else begin
                x = b;
                y = a;
            end
            ex  = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
            ey  = (y[30:23] == 8'h00) ? 8'd1 : y[30:23];
            mx  = {x[30:23] != 8'h00, x[22:0]};
            my  = {y[30:23] != 8'h00, y[22:0]};
            d   = ex - ey;
            t   = {my, 26'b0} >> d;
            if (d >= 8'd50) begin
                al = {26'b0, |my};
            end else begin
                al = {t[49:24], |t[23:0]};
            end
            bg  = {mx, 3'b0};
            sub = x[31] ^ y[31];
            s   = sub ? ({1'b0, bg} - {1'b0, al}) : ({1'b0, bg} + {1'b0, al});
            lz  = lzc27(s[26:0]);
            if (s[27]) begin
                m  = {s[27:2], s[1] | s[0]};
                e  = {1'b0, ex} + 9'd1;
                sh = 5'd0;
            end else if ({1'b0, ex} > {4'b0, lz}) begin
                sh = lz;
                m  = s[26:0] << sh;
                e  = {1'b0, ex} - {4'b0, lz};
            end else begin
                sh = 5'(ex - 8'd1);
                m  = s[26:0] << sh;
                e  = 9'd1;
            end
            ru     = m[2] & (m[1] | m[0] | m[3]);
            r      = {1'b0, m[26:3]} + {24'b0, ru};
            denorm = 1'b0;
            if (r[24]) begin
                e    = e + 9'd1;
                frac = 23'b0;
            end else begin
                frac = r[22:0];
                if (!r[23]) denorm = 1'b1;
            end
            if (s == 28'b0) begin
                res = {~sub & x[31], 31'b0};
            end else if (e >= 9'd255) begin
                res = {x[31], 8'hFF, 23'b0};
            end else if (denorm) begin
                res = {x[31], 31'b0};
            end else begin
                res = {x[31], e[7:0], frac};
            end
        end
        return res;
    endfunction

    function automatic logic [15:0] fp_to_bf16(input logic [31:0] u);
        logic [31:0] t;
        logic [15:0] res;
        t = u + 32'h0000_7FFF + {31'b0, u[16]};
        if (u[30:0] > 31'h7F80_0000) begin
            res = BF_QNAN;
        end else if (u[30:23] == 8'h00) begin
            res = {u[31], 15'b0};
        end else begin
            res = t[31:16];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/pcb_ram.sv =====
// Row-wide synchronous RAM written one 64-bit word at a time, read a whole row.
module pcb_ram
    import pcb_pkg::*;
#(
    parameter int ROWS  = 8,
    parameter int LANES = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [$clog2(ROWS)+$clog2(LANES)-1:0]      i_waddr,
    input  logic [WORD_W-1:0]                          i_wdata,
    input  logic                                       i_re,
    input  logic [$clog2(ROWS)-1:0]                    i_raddr,
    output logic [LANES*WORD_W-1:0]                    o_rdata
);
    localparam int LB = $clog2(LANES);
    localparam int RB = $clog2(ROWS);

    logic [LANES*WORD_W-1:0] r_mem [ROWS];
    logic [LANES*WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[RB+LB-1:LB]][i_waddr[LB-1:0]*WORD_W +: WORD_W] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/pcb_lanes.sv =====
// 32 output lanes: product register, fp32 accumulator and bf16 rounding.
module pcb_lanes
    import pcb_pkg::*;
(
    input  logic                        i_clk,
    input  t_lane_ctl                   i_ctl,
    input  logic [IN_CH*HALF_W-1:0]     i_pixel,
    input  logic [W_LANES*WORD_W-1:0]   i_wrow,
    input  logic [B_LANES*WORD_W-1:0]   i_brow,
    output logic [OUT_CH*HALF_W-1:0]    o_result
);
    logic [31:0] r_prod [OUT_CH];
    logic [31:0] r_acc  [OUT_CH];
    logic [15:0] x_half;

    assign x_half = i_pixel[{i_ctl.pair, i_ctl.k}*HALF_W +: HALF_W];

    always_ff @(posedge i_clk) begin
        for (int o = 0; o < OUT_CH; o++) begin
            if (i_ctl.mul_en) begin
                r_prod[o] <= bf_mul(x_half, i_wrow[(2*o + int'(i_ctl.k))*HALF_W +: HALF_W]);
            end
            if (i_ctl.add_bias) begin
                r_acc[o] <= fp_add(r_acc[o], {i_brow[o*HALF_W +: HALF_W], 16'b0});
            end else if (i_ctl.add_en) begin
                r_acc[o] <= fp_add(i_ctl.add_first ? 32'h0 : r_acc[o], r_prod[o]);
            end
        end
    end

    always_comb begin
        for (int o = 0; o < OUT_CH; o++) begin
            o_result[o*HALF_W +: HALF_W] = fp_to_bf16(r_acc[o]);
        end
    end
endmodule

// ===== rtl/core/pointwise_conv_periodic_bias_bf16.sv =====
// Pointwise bf16 convolution, 16 to 32 channels, with a 4x4 periodic bias.
//
// Input channel: i_in_valid / o_in_stall. A request carries an action: a pixel
// (16 bf16 channels on i_lane_data_0..3), a weight word load or a bias word
// load (word on i_lane_data_0, address on i_word_index). Loads give no result
// and clear the row and column counters.
// Output channel: o_out_valid / i_out_stall, 32 bf16 outputs on o_result_0..7.
// A pixel runs in the lane datapath as 16 weight-row reads and
// multiply/accumulate steps (one input channel per step, 32 lanes wide), one
// bias add and one rounding step; the result register is loaded at the
// rounding step once it is free. A new pixel is taken only after the last one
// has left the lanes, since each lane has a single shared accumulator.
// The result register parts the two sides: the next pixel is taken while a
// result waits. If the receiver stalls, the finished pixel holds in the lanes
// and the input stays stalled until the result register frees.
// Reset (i_rst_n low, synchronous) clears counters and valid, sets sizes to 64;
// the weight and bias memories must be loaded before pixels are sent.
// Sizes are written on i_cfg_we with i_cfg_idx 0 (width) or 1 (height).
module pointwise_conv_periodic_bias_bf16
    import pcb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [6:0]           i_word_index,
    input  logic [63:0]          i_lane_data_0,
    input  logic [63:0]          i_lane_data_1,
    input  logic [63:0]          i_lane_data_2,
    input  logic [63:0]          i_lane_data_3,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [63:0]          o_result_0,
    output logic [63:0]          o_result_1,
    output logic [63:0]          o_result_2,
    output logic [63:0]          o_result_3,
    output logic [63:0]          o_result_4,
    output logic [63:0]          o_result_5,
    output logic [63:0]          o_result_6,
    output logic [63:0]          o_result_7,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);
    logic                       r_busy;
    logic [STEP_W-1:0]          r_step;
    logic [3:0]                 r_phase;
    logic [IN_CH*HALF_W-1:0]    r_pixel;
    logic [CNT_W-1:0]           r_col, r_row;
    logic [SIZE_W-1:0]          r_width, r_height;
    logic                       r_out_v;
    logic [OUT_CH*HALF_W-1:0]   r_res;

    logic                       in_acc, is_pixel, is_load, out_free, finish;
    logic [SIZE_W-1:0]          w_eff, h_eff, nc, nr;
    logic [W_LANES*WORD_W-1:0]  wrow;
    logic [B_LANES*WORD_W-1:0]  brow;
    logic [OUT_CH*HALF_W-1:0]   lane_res;
    t_lane_ctl                  ctl;
    logic [STEP_W-1:0]          mstep, astep;

    assign o_in_stall = r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    assign is_pixel   = (t_action'(i_action) == ACT_PIXEL);
    assign is_load    = (t_action'(i_action) == ACT_WLOAD) || (t_action'(i_action) == ACT_BLOAD);
    assign out_free   = !r_out_v || !i_out_stall;
    assign finish     = r_busy && (r_step == STEP_ROUND) && out_free;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v == '0) res = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_SIZE)) res = SIZE_W'(MAX_SIZE);
        return res;
    endfunction

    assign w_eff = clamp_size(r_width);
    assign h_eff = clamp_size(r_height);
    assign nc    = {1'b0, r_col} + SIZE_W'(1);
    assign nr    = {1'b0, r_row} + SIZE_W'(1);

    // step j of the product stage runs at r_step j+1, of the add stage at j+2
    assign mstep = r_step - STEP_W'(1);
    assign astep = r_step - STEP_W'(2);

    always_comb begin
        ctl.mul_en    = r_busy && (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(MAC_STEPS));
        ctl.pair      = mstep[3:1];
        ctl.k         = ~mstep[0];
        ctl.add_en    = r_busy && (r_step >= STEP_W'(2)) && (r_step <= STEP_W'(MAC_STEPS + 1));
        ctl.add_first = (astep == '0);
        ctl.add_bias  = r_busy && (r_step == STEP_BIAS);
    end

    pcb_ram #(.ROWS(W_ROWS), .LANES(W_LANES)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (in_acc && (t_action'(i_action) == ACT_WLOAD)),
        .i_waddr (i_word_index),
        .i_wdata (i_lane_data_0),
        .i_re    (r_busy && (r_step < STEP_W'(MAC_STEPS))),
        .i_raddr (r_step[3:1]),
        .o_rdata (wrow)
    );

    pcb_ram #(.ROWS(B_ROWS), .LANES(B_LANES)) u_bmem (
        .i_clk   (i_clk),
        .i_we    (in_acc && (t_action'(i_action) == ACT_BLOAD)),
        .i_waddr (i_word_index),
        .i_wdata (i_lane_data_0),
        .i_re    (r_busy && (r_step == '0)),
        .i_raddr (r_phase),
        .o_rdata (brow)
    );

    pcb_lanes u_lanes (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_pixel  (r_pixel),
        .i_wrow   (wrow),
        .i_brow   (brow),
        .o_result (lane_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_width  <= SIZE_W'(64);
            r_height <= SIZE_W'(64);
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_WIDTH) r_width <= i_cfg_data;
                else r_height <= i_cfg_data;
            end
            if (in_acc && is_load) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc && is_pixel) begin
                r_busy <= 1'b1;
                r_step <= '0;
                if (nc >= w_eff) begin
                    r_col <= '0;
                    r_row <= (nr >= h_eff) ? '0 : nr[CNT_W-1:0];
                end else begin
                    r_col <= nc[CNT_W-1:0];
                end
            end
            if (r_busy && (r_step != STEP_ROUND)) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (finish) begin
                r_busy  <= 1'b0;
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_pixel) begin
            r_phase <= {r_row[1:0], r_col[1:0]};
            r_pixel <= {i_lane_data_3, i_lane_data_2, i_lane_data_1, i_lane_data_0};
        end
        if (finish) begin
            r_res <= lane_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_result_0  = r_res[0*WORD_W +: WORD_W];
    assign o_result_1  = r_res[1*WORD_W +: WORD_W];
    assign o_result_2  = r_res[2*WORD_W +: WORD_W];
    assign o_result_3  = r_res[3*WORD_W +: WORD_W];
    assign o_result_4  = r_res[4*WORD_W +: WORD_W];
    assign o_result_5  = r_res[5*WORD_W +: WORD_W];
    assign o_result_6  = r_res[6*WORD_W +: WORD_W];
    assign o_result_7  = r_res[7*WORD_W +: WORD_W];
endmodule
